FILE: hw/rtl/mevs_pkg.sv
// Shared types and constants for the missing energy vector sum block.
package mevs_pkg;

	localparam int unsigned SUM_W      = 22;
	localparam int unsigned ABS_W      = SUM_W - 1;
	localparam int unsigned PROD_W     = 2 * ABS_W;
	localparam int unsigned MSQ_W      = 32;
	localparam int unsigned ROOT_W     = MSQ_W / 2;
	localparam int unsigned ROOT_STEPS = MSQ_W / 2;
	localparam int unsigned SUM_CAP    = 2097151;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 96;

	// tuser bit positions on the input side
	localparam int unsigned USER_SIDE  = 0;
	localparam int unsigned USER_VALID = 1;

	typedef struct packed {
		logic accum;     // record beat taken
		logic sq_en;     // register a square
		logic sq_sel;    // 0: x component, 1: y component
		logic add_en;    // add squares, saturate, seed root
		logic root_step; // one root digit
		logic load;      // load output register
	} ctrl_cmd_t;

endpackage

FILE: hw/rtl/mevs_dp.sv
// Datapath: saturating accumulators, shared squarer, saturating add, digit-serial root.
module mevs_dp #(
	parameter int unsigned MAX_RECORDS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mevs_pkg::ctrl_cmd_t                 cmd,
	input  logic signed [15:0]                  part_ex,
	input  logic signed [15:0]                  part_ey,
	input  logic                                fpga_side,
	input  logic                                record_valid,
	input  logic                                event_last,
	output logic [mevs_pkg::OUT_DATA_W-1:0]     result
);

	localparam int unsigned SumW    = mevs_pkg::SUM_W;
	localparam int unsigned LimRaw  = MAX_RECORDS * 65536;
	localparam int unsigned Lim     = (LimRaw > mevs_pkg::SUM_CAP) ? mevs_pkg::SUM_CAP : LimRaw;
	localparam logic signed [SumW:0] SumHi = (SumW+1)'(Lim);
	localparam logic signed [SumW:0] SumLo = -SumHi;

	logic signed [SumW-1:0]            sum_x_q, sum_y_q;
	logic signed [SumW-1:0]            mx_q, my_q;
	logic [mevs_pkg::PROD_W-1:0]       sqx_q, sqy_q;
	logic [mevs_pkg::MSQ_W-1:0]        msq_q, rem_q, root_q, bit_q;
	logic [mevs_pkg::OUT_DATA_W-1:0]   result_q;

	logic signed [17:0]                dx, dy;
	logic signed [SumW:0]              add_x, add_y, sat_x, sat_y, neg_x, neg_y;
	logic [mevs_pkg::ABS_W-1:0]        ax, ay, op;
	logic [mevs_pkg::PROD_W-1:0]       prod;
	logic [mevs_pkg::PROD_W:0]         sq_sum;
	logic [mevs_pkg::MSQ_W-1:0]        msq_sat, trial;

	function automatic logic signed [SumW:0] sat(input logic signed [SumW:0] v);
		if (v > SumHi)
			return SumHi;
		else if (v < SumLo)
			return SumLo;
		else
			return v;
	endfunction

	always_comb begin
		dx = {part_ex[15], part_ex, 1'b0};
		dy = {part_ey[15], part_ey, 1'b0};
		if (!fpga_side) begin
			dx = -dx;
			dy = -dy;
		end
		if (!record_valid) begin
			dx = '0;
			dy = '0;
		end
		add_x = {sum_x_q[SumW-1], sum_x_q} + (SumW+1)'(dx);
		add_y = {sum_y_q[SumW-1], sum_y_q} + (SumW+1)'(dy);
		sat_x = sat(add_x);
		sat_y = sat(add_y);
		neg_x = -sat_x;
		neg_y = -sat_y;
	end

	// magnitudes stay below 2^21 since the limit is symmetric
	assign ax = mx_q[SumW-1] ? mevs_pkg::ABS_W'(-mx_q) : mevs_pkg::ABS_W'(mx_q);
	assign ay = my_q[SumW-1] ? mevs_pkg::ABS_W'(-my_q) : mevs_pkg::ABS_W'(my_q);
	assign op = cmd.sq_sel ? ay : ax;
	assign prod = op * op;

	assign sq_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign msq_sat = (|sq_sum[mevs_pkg::PROD_W:mevs_pkg::MSQ_W]) ? '1
		: sq_sum[mevs_pkg::MSQ_W-1:0];
	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.accum) begin
			if (event_last) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else begin
				sum_x_q <= sat_x[SumW-1:0];
				sum_y_q <= sat_y[SumW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum && event_last) begin
			mx_q <= neg_x[SumW-1:0];
			my_q <= neg_y[SumW-1:0];
		end
		if (cmd.sq_en) begin
			if (cmd.sq_sel)
				sqy_q <= prod;
			else
				sqx_q <= prod;
		end
		if (cmd.add_en) begin
			msq_q  <= msq_sat;
			rem_q  <= msq_sat;
			root_q <= '0;
			bit_q  <= mevs_pkg::MSQ_W'(1) << (mevs_pkg::MSQ_W - 2);
		end else if (cmd.root_step) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.load)
			result_q <= {4'b0000, root_q[mevs_pkg::ROOT_W-1:0], msq_q, my_q, mx_q};
	end

	assign result = result_q;

endmodule

FILE: hw/rtl/mevs_ctrl.sv
// Controller: accumulate phase, square and root sequence, output register handshake.
module mevs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output mevs_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;

	localparam int unsigned CntW = $clog2(mevs_pkg::ROOT_STEPS);
	localparam logic [CntW-1:0] CntLast = CntW'(mevs_pkg::ROOT_STEPS - 1);

	logic [2:0]      state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            m_tvalid_q;
	logic            accept, load;

	assign s_tready = (state_q == ST_ACC);
	assign accept   = s_tvalid && s_tready;
	assign load     = (state_q == ST_LOAD) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd           = '0;
		cmd.accum     = accept;
		cmd.sq_en     = (state_q == ST_SQX) || (state_q == ST_SQY);
		cmd.sq_sel    = (state_q == ST_SQY);
		cmd.add_en    = (state_q == ST_ADD);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.load      = load;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC:  if (accept && s_tlast) state_d = ST_SQX;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_ROOT;
			ST_ROOT: if (cnt_q == CntLast) state_d = ST_LOAD;
			ST_LOAD: if (load) state_d = ST_ACC;
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACC;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ADD)
				cnt_q <= '0;
			else if (state_q == ST_ROOT)
				cnt_q <= cnt_q + 1'b1;
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/missing_energy_vector_sum.sv
// Top level of the missing energy vector sum block.
//
//   channel  dir  tdata (low bit up)                           tuser / tlast
//   s_*      in   part_ex[15:0], part_ey[31:16]                tuser: fpga_side, record_valid;
//                                                              tlast: event_last
//   m_*      out  missing_ex[21:0], missing_ey[43:22],         none
//                 magnitude_squared[75:44], magnitude[91:76]
//
// A record beat without tlast is taken at once in the accumulate phase. A beat with tlast closes the event; the
// result is then formed in two squarer steps, one add, 16 root digits and one load,
// during which s_tready is low; the load waits while the previous result is still unread.
// The root unit resolves one bit per cycle.
// The result waits in the output register; records of the next event are taken meanwhile.
// Asynchronous reset clears the sums and the control state.
module missing_energy_vector_sum #(
	parameter int unsigned MAX_RECORDS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mevs_pkg::IN_DATA_W-1:0]      s_tdata,  // part_ex, part_ey
	input  logic [mevs_pkg::IN_USER_W-1:0]      s_tuser,  // fpga_side, record_valid
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mevs_pkg::OUT_DATA_W-1:0]     m_tdata   // missing_ex, missing_ey,
	                                                      // magnitude_squared, magnitude
);

	mevs_pkg::ctrl_cmd_t cmd;

	mevs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	mevs_dp #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.part_ex      (s_tdata[15:0]),
		.part_ey      (s_tdata[31:16]),
		.fpga_side    (s_tuser[mevs_pkg::USER_SIDE]),
		.record_valid (s_tuser[mevs_pkg::USER_VALID]),
		.event_last   (s_tlast),
		.result       (m_tdata)
	);

endmodule

FILE: test/missing_energy_vector_sum_test.sv
// Self-checking testbench for the missing energy vector sum block.
module missing_energy_vector_sum_test;

	localparam int unsigned MAX_RECORDS = 16;
	localparam longint      RAW_LIMIT   = longint'(MAX_RECORDS) * 65536;
	localparam longint      SUM_LIMIT   = (RAW_LIMIT > longint'(mevs_pkg::SUM_CAP))
	                                      ? longint'(mevs_pkg::SUM_CAP) : RAW_LIMIT;
	localparam longint      MSQ_MAX     = 64'h0000_0000_FFFF_FFFF;
	localparam int          ITEMS_PER_PHASE = 285;
	localparam int          HOLD_CYCLES     = 300;
	localparam int          DRAIN_CYCLES    = 40;

	typedef struct {
		logic signed [mevs_pkg::SUM_W-1:0]  ex;
		logic signed [mevs_pkg::SUM_W-1:0]  ey;
		logic        [mevs_pkg::MSQ_W-1:0]  msq;
		logic        [mevs_pkg::ROOT_W-1:0] mag;
	} energy_result_t;

	typedef struct {
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		bit                 side;
		bit                 valid;
		bit                 last;
		bit                 typed;
		energy_result_t     res;
	} record_row_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [mevs_pkg::IN_DATA_W-1:0]  s_tdata  = '0;  // part_ex, part_ey
	logic [mevs_pkg::IN_USER_W-1:0]  s_tuser  = '0;  // fpga_side, record_valid
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// missing_ex, missing_ey, magnitude_squared, magnitude
	logic [mevs_pkg::OUT_DATA_W-1:0] m_tdata;

	missing_energy_vector_sum #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	longint         run_sum_x;
	longint         run_sum_y;
	energy_result_t pending_results[$];
	record_row_t    directed_rows[$];
	int             errors          = 0;
	int             sender_idle_pct = 0;
	int             recv_idle_pct   = 0;
	bit             hold_request    = 1'b0;

	function automatic longint clamp_sum(longint v);
		if (v > SUM_LIMIT)
			return SUM_LIMIT;
		if (v < -SUM_LIMIT)
			return -SUM_LIMIT;
		return v;
	endfunction

	function automatic logic [mevs_pkg::ROOT_W-1:0] floor_root(logic [mevs_pkg::MSQ_W-1:0] v);
		longint r;
		longint t;
		r = 0;
		for (int b = mevs_pkg::ROOT_W - 1; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= longint'(v))
				r = t;
		end
		return r[mevs_pkg::ROOT_W-1:0];
	endfunction

	// Updates the running sums; returns 1 with the event result when the record closes it.
	function automatic bit fold_record(record_row_t row, output energy_result_t res);
		longint dx;
		longint dy;
		longint mx;
		longint my;
		longint sq;
		dx = longint'(row.ex) * 2;
		dy = longint'(row.ey) * 2;
		res = '{default: '0};
		if (row.valid) begin
			if (!row.side) begin
				dx = -dx;
				dy = -dy;
			end
			run_sum_x = clamp_sum(run_sum_x + dx);
			run_sum_y = clamp_sum(run_sum_y + dy);
		end
		if (!row.last)
			return 1'b0;
		mx = -run_sum_x;
		my = -run_sum_y;
		sq = mx * mx + my * my;
		if (sq > MSQ_MAX)
			sq = MSQ_MAX;
		res.ex  = mx[mevs_pkg::SUM_W-1:0];
		res.ey  = my[mevs_pkg::SUM_W-1:0];
		res.msq = sq[mevs_pkg::MSQ_W-1:0];
		res.mag = floor_root(sq[mevs_pkg::MSQ_W-1:0]);
		run_sum_x = 0;
		run_sum_y = 0;
		return 1'b1;
	endfunction

	task automatic send_record(record_row_t row);
		energy_result_t res;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {row.ey, row.ex};
		s_tuser  <= {row.valid, row.side};
		s_tlast  <= row.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (fold_record(row, res))
			pending_results.push_back(row.typed ? row.res : res);
	endtask

	function automatic logic signed [15:0] pick_part(int style);
		int choice;
		case (style)
			0: begin
				return 16'($urandom());
			end
			1: begin
				return 16'($signed($urandom_range(400)) - 200);
			end
			default: begin
				choice = $urandom_range(4);
				case (choice)
					0: return 16'sh7FFF;
					1: return -16'sh8000;
					2: return 16'sh0000;
					3: return -16'sh0001;
					default: return 16'sh0001;
				endcase
			end
		endcase
	endfunction

	// One event of random length; some drive the sums into saturation, some carry only invalid records.
	task automatic send_random_event(inout int count);
		record_row_t row;
		int          len;
		int          style;
		int          kind;
		bit          fixed_side;
		kind = $urandom_range(99);
		len  = (kind < 12) ? $urandom_range(30, 40) : $urandom_range(1, 20);
		fixed_side = $urandom_range(1);
		style = $urandom_range(2);
		for (int i = 0; i < len; i++) begin
			row.typed = 1'b0;
			row.res   = '{default: '0};
			row.last  = (i == len - 1);
			if (kind < 12) begin
				// push the two sums towards opposite rails
				row.ex    = ($urandom_range(9) < 8) ? 16'sh7FFF : pick_part(0);
				row.ey    = ($urandom_range(9) < 8) ? -16'sh8000 : pick_part(0);
				row.side  = fixed_side;
				row.valid = 1'b1;
			end else if (kind < 17) begin
				row.ex    = pick_part(0);
				row.ey    = pick_part(0);
				row.side  = $urandom_range(1);
				row.valid = 1'b0;
			end else begin
				row.ex    = pick_part(($urandom_range(3) == 0) ? $urandom_range(2) : style);
				row.ey    = pick_part(($urandom_range(3) == 0) ? $urandom_range(2) : style);
				row.side  = ($urandom_range(3) == 0) ? ~fixed_side : fixed_side;
				row.valid = ($urandom_range(9) != 0);
			end
			send_record(row);
			count++;
		end
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Result side: random back-pressure, one long hold on request, checks every beat.
	initial begin
		energy_result_t exp_r;
		int             hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result beat, data %h", $time, m_tdata);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("missing_ex", exp_r.ex, $signed(m_tdata[21:0]));
					check_field("missing_ey", exp_r.ey, $signed(m_tdata[43:22]));
					check_field("magnitude_squared", exp_r.msq, m_tdata[75:44]);
					check_field("magnitude", exp_r.mag, m_tdata[91:76]);
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#(12 * 200000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int          count;
		run_sum_x = 0;
		run_sum_y = 0;

		// empty event closes with all zeros
		directed_rows.push_back('{16'sh0, 16'sh0, 1'b0, 1'b0, 1'b1, 1'b1,
			'{22'sh0, 22'sh0, 32'h0, 16'h0}});
		// extremes, both sides; squared magnitude saturates
		directed_rows.push_back('{16'sh7FFF, -16'sh8000, 1'b1, 1'b1, 1'b1, 1'b1,
			'{-22'sd65534, 22'sd65536, 32'hFFFF_FFFF, 16'hFFFF}});
		directed_rows.push_back('{16'sh7FFF, -16'sh8000, 1'b0, 1'b1, 1'b1, 1'b1,
			'{22'sd65534, -22'sd65536, 32'hFFFF_FFFF, 16'hFFFF}});
		// small event with an ignored record inside and an empty closing beat
		directed_rows.push_back('{16'sd3, 16'sd4, 1'b0, 1'b1, 1'b0, 1'b0,
			'{22'sh0, 22'sh0, 32'h0, 16'h0}});
		directed_rows.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 1'b0,
			'{22'sh0, 22'sh0, 32'h0, 16'h0}});
		directed_rows.push_back('{16'sh0, 16'sh0, 1'b1, 1'b0, 1'b1, 1'b1,
			'{22'sd6, 22'sd8, 32'd100, 16'd10}});
		// one record too many for the sum range
		for (int i = 0; i <= MAX_RECORDS; i++)
			directed_rows.push_back('{16'sh7FFF, -16'sh8000, 1'b1, 1'b1, (i == MAX_RECORDS),
				(i == MAX_RECORDS), '{-22'sd1048576, 22'sd1048576, 32'hFFFF_FFFF, 16'hFFFF}});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 10;
		recv_idle_pct   = 63;
		foreach (directed_rows[i])
			send_record(directed_rows[i]);

		count = 0;
		while (count < ITEMS_PER_PHASE)
			send_random_event(count);

		sender_idle_pct = 63;
		recv_idle_pct   = 10;
		count = 0;
		while (count < ITEMS_PER_PHASE)
			send_random_event(count);

		sender_idle_pct = 0;
		recv_idle_pct   = 0;
		hold_request    = 1'b1;
		count = 0;
		while (count < ITEMS_PER_PHASE)
			send_random_event(count);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/mevs_pkg.sv
hw/rtl/mevs_dp.sv
hw/rtl/mevs_ctrl.sv
hw/rtl/missing_energy_vector_sum.sv
test/missing_energy_vector_sum_test.sv
